[rtl/core/msb_pkg.sv]
// Shared types and constants of the monochrome sprite blitter.
// Used by the front end, the job queue, the back end and the top level.
`default_nettype none

package msb_pkg;

   // Fixed field widths.
   localparam int SCREEN_W_BITS = 11;
   localparam int BYTE_ADDR_W   = 20;
   localparam int PIX_COUNT_W   = 6;
   localparam int LANE_CNT_W    = 3;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

   localparam logic [SCREEN_W_BITS-1:0] SCREEN_WIDTH_RESET = 11'd240;

   // Opcodes.
   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Sprite width codes; any other code draws the widest sprite.
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;

   // Draw modes.
   localparam logic [1:0] MODE_COPY = 2'd0;
   localparam logic [1:0] MODE_OR   = 2'd1;
   localparam logic [1:0] MODE_XOR  = 2'd2;
   localparam logic [1:0] MODE_AND  = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [7:0]  row_offset;
      logic [31:0] sprite_row;
      logic [1:0]  sprite_width;
      logic [1:0]  draw_mode;
      logic        last_row;
      logic [11:0] read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       sprite_done;
      logic       clipped;
   } rsp_type;

   // Classified work for the back end: first byte, bit offset, pixels in
   // column order (column 0 in bit 0) and the number of bytes touched.
   typedef struct packed {
      logic                   opcode;
      logic [BYTE_ADDR_W-1:0] byte_addr;
      logic [2:0]             bit_off;
      logic [31:0]            pixels;
      logic [PIX_COUNT_W-1:0] pix_count;
      logic [LANE_CNT_W-1:0]  lane_count;
      logic [1:0]             draw_mode;
      logic                   last_row;
   } job_type;

endpackage

`default_nettype wire

[rtl/core/msb_front.sv]
// Front end of the sprite blitter: accepts requests, computes the bit
// address of a row and classifies it into a job. Depends on msb_pkg.
`default_nettype none

module msb_front #(
   parameter int MAX_SPRITE_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire msb_pkg::req_type    req_data,
   input  wire logic [10:0]         screen_width,
   input  wire logic                clearing,
   output logic                     job_valid,
   input  wire logic                job_full,
   output msb_pkg::job_type         job_data
);
   import msb_pkg::*;

   localparam logic [PIX_COUNT_W-1:0] W8 =
      PIX_COUNT_W'((MAX_SPRITE_WIDTH < 8) ? MAX_SPRITE_WIDTH : 8);
   localparam logic [PIX_COUNT_W-1:0] W16 =
      PIX_COUNT_W'((MAX_SPRITE_WIDTH < 16) ? MAX_SPRITE_WIDTH : 16);
   localparam logic [PIX_COUNT_W-1:0] W32 = PIX_COUNT_W'(MAX_SPRITE_WIDTH);

   logic        stage_valid_ff, stage_valid_in;
   req_type     stage_ff;
   logic [21:0] prod_ff, prod_in;
   logic        accept;
   logic [10:0] sum_y;
   logic [21:0] base;
   logic [PIX_COUNT_W-1:0] width;
   logic [31:0] reversed;

   // The stage holds one request; it drains into the queue when there is room.
   assign full      = clearing | (stage_valid_ff & job_full);
   assign accept    = push & ~full;
   assign job_valid = stage_valid_ff;

   // Row number times the stride, registered before the add of the column.
   assign sum_y   = {1'b0, req_data.pos_y} + {3'b000, req_data.row_offset};
   assign prod_in = {11'b0, sum_y} * {11'b0, screen_width};

   assign stage_valid_in = accept | (stage_valid_ff & job_full);

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= req_data;
         prod_ff  <= prod_in;
      end
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Classify the staged request into byte address, offset and pixel order.
   always_comb begin
      base = prod_ff + {12'b0, stage_ff.pos_x};
      case (stage_ff.sprite_width)
         WIDTH_8:  width = W8;
         WIDTH_16: width = W16;
         default:  width = W32;
      endcase
      for (int i = 0; i < 32; i++) begin
         reversed[i] = stage_ff.sprite_row[31 - i];
      end

      job_data.opcode    = stage_ff.opcode;
      job_data.draw_mode = stage_ff.draw_mode;
      job_data.last_row  = stage_ff.last_row;
      job_data.pix_count = width;
      job_data.pixels    = reversed >> (6'd32 - width);
      if (stage_ff.opcode == OP_READ) begin
         job_data.byte_addr  = {8'b0, stage_ff.read_address};
         job_data.bit_off    = 3'd0;
         job_data.lane_count = 3'd1;
      end else begin
         job_data.byte_addr  = {1'b0, base[21:3]};
         job_data.bit_off    = base[2:0];
         job_data.lane_count =
            LANE_CNT_W'(({3'b000, base[2:0]} + width + 6'd7) >> 3);
      end
   end

endmodule

`default_nettype wire

[rtl/core/msb_fifo.sv]
// Short job queue between the front end and the back end.
// Depends on msb_pkg for the job type and depth.
`default_nettype none

module msb_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire msb_pkg::job_type din,
   input  wire logic             pop,
   output logic                  empty,
   output msb_pkg::job_type      dout
);
   import msb_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign dout    = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/msb_back.sv]
// Back end of the sprite blitter: owns the framebuffer memory, clears it
// after reset and runs the byte-wise read-modify-write. Depends on msb_pkg.
`default_nettype none

module msb_back #(
   parameter int FRAME_BYTES      = 4096,
   parameter int MAX_SPRITE_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_empty,
   input  wire msb_pkg::job_type job_data,
   output logic                  job_pop,
   output logic                  clearing,
   output logic                  empty,
   input  wire logic             pop,
   output msb_pkg::rsp_type      rsp_data
);
   import msb_pkg::*;

   localparam int AW      = $clog2(FRAME_BYTES);
   localparam int LANES   = (MAX_SPRITE_WIDTH + 14) / 8;
   localparam int LW      = LANES * 8;
   localparam int LIDX_W  = $clog2(LANES);
   localparam logic [BYTE_ADDR_W-1:0] FRAME_LIMIT = BYTE_ADDR_W'(FRAME_BYTES);
   localparam logic [AW-1:0] CLR_LAST = AW'(FRAME_BYTES - 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_FINISH} state_type;

   state_type              state_ff, state_in;
   job_type                work_ff, work_in;
   logic [LANE_CNT_W-1:0]  lane_ff, lane_in;
   logic                   clip_ff, clip_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   rsp_type                pend_ff, pend_in;
   rsp_type                result;

   logic [7:0]             frame_mem_ff [FRAME_BYTES];
   logic [7:0]             rd_data_ff;
   logic                   wr_en;
   logic [AW-1:0]          wr_idx;
   logic [7:0]             wr_data;
   logic [BYTE_ADDR_W-1:0] rd_addr;

   logic [BYTE_ADDR_W-1:0] cur_addr;
   logic                   in_range, last_lane, slot_free;
   logic [31:0]            mask32;
   logic [LW-1:0]          data_vec, mask_vec;
   logic [LIDX_W+2:0]      lane_bit;
   logic [7:0]             s_byte, m_byte, new_byte;

   assign clearing = (state_ff == ST_CLEAR);
   assign empty    = ~rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Pixels and their mask placed at the bit offset, split into byte lanes.
   assign mask32   = 32'((33'd1 << work_ff.pix_count) - 33'd1);
   assign data_vec = LW'(work_ff.pixels) << work_ff.bit_off;
   assign mask_vec = LW'(mask32) << work_ff.bit_off;
   assign lane_bit = {lane_ff[LIDX_W-1:0], 3'b000};
   assign s_byte   = data_vec[lane_bit +: 8];
   assign m_byte   = mask_vec[lane_bit +: 8];

   assign cur_addr  = work_ff.byte_addr + BYTE_ADDR_W'(lane_ff);
   assign in_range  = (cur_addr < FRAME_LIMIT);
   assign last_lane = (lane_ff == work_ff.lane_count - 1'b1);
   assign slot_free = ~rsp_valid_ff | pop;

   // Combine the sprite byte with the stored byte by draw mode.
   always_comb begin
      case (work_ff.draw_mode)
         MODE_COPY: new_byte = (rd_data_ff & ~m_byte) | (s_byte & m_byte);
         MODE_OR:   new_byte = rd_data_ff | s_byte;
         MODE_XOR:  new_byte = rd_data_ff ^ s_byte;
         default:   new_byte = rd_data_ff & ~(m_byte & ~s_byte);
      endcase
   end

   // Result of the item once its last byte has been handled.
   always_comb begin
      if (work_ff.opcode == OP_READ) begin
         result.read_data   = in_range ? rd_data_ff : 8'd0;
         result.sprite_done = 1'b0;
         result.clipped     = 1'b0;
      end else begin
         result.read_data   = 8'd0;
         result.sprite_done = work_ff.last_row;
         result.clipped     = clip_ff | ~in_range;
      end
   end

   // Sequencer: clearing pass, job fetch, one byte per cycle, result hand-off.
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      lane_in      = lane_ff;
      clip_in      = clip_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~pop;
      job_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = cur_addr[AW-1:0];
      wr_data      = new_byte;
      rd_addr      = cur_addr + 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_ff;
            wr_data = 8'd0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = job_data.byte_addr;
            if (!job_empty) begin
               job_pop  = 1'b1;
               work_in  = job_data;
               lane_in  = '0;
               clip_in  = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (work_ff.opcode == OP_DRAW) begin
               wr_en = in_range;
               if (!in_range) begin
                  clip_in = 1'b1;
               end
            end
            if (last_lane) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = result;
                  state_in     = ST_IDLE;
               end else begin
                  pend_in  = result;
                  state_in = ST_FINISH;
               end
            end else begin
               lane_in = lane_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         lane_ff      <= '0;
         clip_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         clip_ff      <= clip_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Framebuffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= frame_mem_ff[rd_addr[AW-1:0]];
   end

endmodule

`default_nettype wire

[rtl/core/mono_sprite_blitter.sv]
// Top level of the monochrome sprite blitter: screen width register and
// the front end, job queue and back end. Depends on msb_pkg.
//
// Usage:
//   Requests enter through push/full with req_data; a request is taken at a
//   clock edge with push high and full low. Opcode draw writes one sprite
//   row (8, 16 or 32 pixels) into the internal framebuffer; opcode read
//   returns one framebuffer byte. Every request yields exactly one response.
//   Responses leave in order through empty/pop with rsp_data; the oldest
//   response is shown while empty is low and taken when pop is high.
//   The screen width (row stride in pixels) is written through
//   csr_valid/csr_ready/csr_data; the user must write it only while the
//   block is idle, and the block itself does not enforce this.
//   Timing: a request is registered in the front stage, where it waits
//   while the queue is full; the back end pops it from the queue in a
//   fetch cycle that also reads the first byte, then handles one
//   framebuffer byte per cycle (1 for a read, up to 5 for a 32-pixel row).
//   Reset clears all FRAME_BYTES bytes of the framebuffer in a pass during
//   which full stays high; the screen width returns to 240.
//   When the receiver stalls, the response register holds, the back end
//   waits on its next result, and the queue and front stage keep taking
//   requests until they fill, after which full goes high.
`default_nettype none

module mono_sprite_blitter #(
   parameter int FRAME_BYTES      = 4096,
   parameter int MAX_SPRITE_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire msb_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output msb_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [10:0]      csr_data
);
   import msb_pkg::*;

   logic [SCREEN_W_BITS-1:0] screen_width_ff, screen_width_in;
   logic                     clearing;
   logic                     job_valid, job_full, job_empty, job_pop;
   job_type                  job_in_data, job_out_data;

   // Screen width register; always ready for a write.
   assign csr_ready       = 1'b1;
   assign screen_width_in = csr_valid ? csr_data : screen_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SCREEN_WIDTH_RESET;
      end else begin
         screen_width_ff <= screen_width_in;
      end
   end

   msb_front #(
      .MAX_SPRITE_WIDTH(MAX_SPRITE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .screen_width(screen_width_ff),
      .clearing    (clearing),
      .job_valid   (job_valid),
      .job_full    (job_full),
      .job_data    (job_in_data)
   );

   msb_fifo u_queue (
      .clock(clock),
      .reset(reset),
      .push (job_valid),
      .full (job_full),
      .din  (job_in_data),
      .pop  (job_pop),
      .empty(job_empty),
      .dout (job_out_data)
   );

   msb_back #(
      .FRAME_BYTES     (FRAME_BYTES),
      .MAX_SPRITE_WIDTH(MAX_SPRITE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_empty(job_empty),
      .job_data (job_out_data),
      .job_pop  (job_pop),
      .clearing (clearing),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
